// File: rtl/core/trace_record_ring_buffer_assert.svh
// Assertion helpers for the trace buffer; clk and rst come from the using scope.
`ifndef TRACE_RECORD_RING_BUFFER_ASSERT_SVH
`define TRACE_RECORD_RING_BUFFER_ASSERT_SVH

// same-cycle implication
`define TRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trace buffer check failed");

// next-cycle implication
`define TRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trace buffer check failed");

`endif

// File: rtl/core/trb_pkg.sv
`timescale 1ns / 1ps

package trb_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int STAMP_BITS_DEF = 64;

  localparam int STAMP_W    = 64;
  localparam int AGE_W      = 10;
  localparam int SLOTS_W    = 11;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic OP_LOG  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_WHEN_FULL = 1'b1;

  typedef struct packed {
    logic             overrun_flag;
    logic [CNT_W-1:0] wrap;
    logic [CNT_W-1:0] wc;
  } status_t;

endpackage

// File: rtl/core/trb_ifs.sv
`timescale 1ns / 1ps

interface trb_in_if (input logic clk);
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [trb_pkg::STAMP_W-1:0] begin_stamp;
  logic [trb_pkg::STAMP_W-1:0] end_stamp;
  logic [trb_pkg::AGE_W-1:0]   age_position;

  modport source (input clk, output valid, input ready,
                  output opcode, begin_stamp, end_stamp, age_position);
  modport sink   (input clk, input valid, output ready,
                  input opcode, begin_stamp, end_stamp, age_position);
endinterface

interface trb_out_if (input logic clk);
  logic                         valid;
  logic                         ready;
  logic [trb_pkg::STAMP_W-1:0]  read_begin;
  logic [trb_pkg::STAMP_W-1:0]  read_end;
  logic                         read_valid;
  logic                         overrun_seen;
  logic [trb_pkg::CNT_W-1:0]    wrap_total;
  logic [trb_pkg::CNT_W-1:0]    write_total;
  logic [trb_pkg::CNT_W-1:0]    oldest_sequence;
  logic [trb_pkg::CNT_W-1:0]    lost_total;
  logic [trb_pkg::SLOTS_W-1:0]  stored_count;

  modport source (input clk, output valid, input ready,
                  output read_begin, read_end, read_valid, overrun_seen, wrap_total,
                  write_total, oldest_sequence, lost_total, stored_count);
  modport sink   (input clk, input valid, output ready,
                  input read_begin, read_end, read_valid, overrun_seen, wrap_total,
                  write_total, oldest_sequence, lost_total, stored_count);
endinterface

interface trb_cfg_if (input logic clk);
  logic                            valid;
  logic                            ready;
  logic [trb_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [trb_pkg::CFG_DATA_W-1:0]  reg_data;

  modport source (input clk, output valid, input ready, output reg_index, reg_data);
  modport sink   (input clk, input valid, output ready, input reg_index, reg_data);
endinterface

// File: rtl/core/trb_mem.sv
`timescale 1ns / 1ps

module trb_mem #(
  parameter int DEPTH      = trb_pkg::DEPTH_DEF,
  parameter int STAMP_BITS = trb_pkg::STAMP_BITS_DEF,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [STAMP_BITS-1:0] wr_begin,
  input  logic [STAMP_BITS-1:0] wr_end,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [STAMP_BITS-1:0] rd_begin,
  output logic [STAMP_BITS-1:0] rd_end
);

  logic [STAMP_BITS-1:0] begin_store [DEPTH];
  logic [STAMP_BITS-1:0] end_store   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      begin_store[wr_addr] <= wr_begin;
      end_store[wr_addr]   <= wr_end;
    end
  end

  // read data holds while the result waits downstream
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_begin <= begin_store[rd_addr];
      rd_end   <= end_store[rd_addr];
    end
  end

endmodule

// File: rtl/core/trb_status.sv
`timescale 1ns / 1ps

module trb_status #(
  parameter int DEPTH = trb_pkg::DEPTH_DEF,
  parameter int PW    = $clog2(DEPTH + 1)
) (
  input  logic                      stop,
  input  logic [PW-1:0]             slots,
  input  logic [PW-1:0]             wp,
  input  trb_pkg::status_t          st,
  output logic [PW-1:0]             stored,
  output logic                      overrun,
  output logic [trb_pkg::CNT_W-1:0] lost,
  output logic [trb_pkg::CNT_W-1:0] oldest
);

  logic [trb_pkg::CNT_W-1:0] slots32;

  assign slots32 = trb_pkg::CNT_W'(slots);
  assign overrun = stop ? st.overrun_flag : (st.wrap != '0);

  always_comb begin
    if (st.wc == '0)
      stored = '0;
    else if (!stop && st.overrun_flag)
      stored = slots;
    else if (wp < slots)
      stored = wp;
    else
      stored = slots;
  end

  assign lost = (overrun && (st.wc > slots32)) ? st.wc - slots32 : '0;

  always_comb begin
    if (st.wc == '0)
      oldest = '0;
    else if (stop || !overrun)
      oldest = trb_pkg::CNT_W'(1);
    else
      oldest = lost + trb_pkg::CNT_W'(1);
  end

endmodule

// File: rtl/core/trb_ctrl.sv
`timescale 1ns / 1ps

module trb_ctrl #(
  parameter int DEPTH = trb_pkg::DEPTH_DEF,
  parameter int PW    = $clog2(DEPTH + 1),
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      opcode,
  input  logic [trb_pkg::AGE_W-1:0] age_position,
  input  logic                      stop,
  input  logic [PW-1:0]             slots,
  input  logic [PW-1:0]             stored,
  output logic [PW-1:0]             wp,
  output trb_pkg::status_t          st,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  output logic                      read_hit
);

  localparam int IW = ((PW > trb_pkg::AGE_W) ? PW : trb_pkg::AGE_W) + 1;

  logic             full;
  logic             log_item;
  logic [PW-1:0]    wp_next;
  trb_pkg::status_t st_next;
  logic [IW-1:0]    start;
  logic [IW-1:0]    sum;
  logic [IW-1:0]    idx;

  assign full     = (wp >= slots);
  assign log_item = accept && (opcode == trb_pkg::OP_LOG);

  // a full buffer is noticed on the write that finds the pointer at the end
  always_comb begin
    wp_next = wp;
    st_next = st;
    if (log_item) begin
      if (full) begin
        st_next.overrun_flag = 1'b1;
        if (!stop) begin
          wp_next = PW'(1);
          if (st.wrap != '1)
            st_next.wrap = st.wrap + trb_pkg::CNT_W'(1);
        end
      end else begin
        wp_next = wp + PW'(1);
      end
      if (st.wc != '1)
        st_next.wc = st.wc + trb_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      st <= '0;
    end else begin
      wp <= wp_next;
      st <= st_next;
    end
  end

  assign wr_en   = log_item && !(full && stop);
  assign wr_addr = full ? '0 : wp[AW-1:0];

  // age zero maps to the slot under the pointer once wrapped
  assign start    = (!stop && st.overrun_flag && (wp < slots)) ? IW'(wp) : '0;
  assign sum      = start + IW'(age_position);
  assign idx      = (sum >= IW'(slots)) ? sum - IW'(slots) : sum;
  assign rd_en    = accept && (opcode == trb_pkg::OP_READ);
  assign rd_addr  = idx[AW-1:0];
  assign read_hit = (opcode == trb_pkg::OP_READ) && (IW'(age_position) < IW'(stored));

endmodule

// File: rtl/core/trace_record_ring_buffer.sv
`timescale 1ns / 1ps
// A result is shown in the cycle after its item is taken; the slot store has one write
// and one registered read port. One item per cycle, so long as the result is not stalled.
// The result holds while stalled and the next item is taken as the result is taken.
// Reset (synchronous): write pointer, counters, overrun flag and result valid clear;
// slots_in_use returns to DEPTH, stop_when_full to 0; slot contents are left as they are.
module trace_record_ring_buffer #(
  parameter int DEPTH      = trb_pkg::DEPTH_DEF,
  parameter int STAMP_BITS = trb_pkg::STAMP_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  trb_in_if.sink       in_item,
  trb_out_if.source    result,
  trb_cfg_if.sink      cfg
);

  `include "trace_record_ring_buffer_assert.svh"

  localparam int PW  = $clog2(DEPTH + 1);
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLW = (PW > trb_pkg::SLOTS_W) ? PW : trb_pkg::SLOTS_W;

  logic [SLW-1:0]            slots_in_use;
  logic                      stop_when_full;
  logic [PW-1:0]             slots;
  logic [PW-1:0]             wp;
  logic [PW-1:0]             stored;
  trb_pkg::status_t          st;
  logic                      in_accept;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic                      read_hit;
  logic [STAMP_BITS-1:0]     rd_begin;
  logic [STAMP_BITS-1:0]     rd_end;
  logic                      out_valid;
  logic                      read_valid;
  logic                      overrun;
  logic [trb_pkg::CNT_W-1:0] lost;
  logic [trb_pkg::CNT_W-1:0] oldest;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use   <= SLW'(DEPTH);
      stop_when_full <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        trb_pkg::REG_SLOTS_IN_USE:   slots_in_use   <= SLW'(cfg.reg_data);
        trb_pkg::REG_STOP_WHEN_FULL: stop_when_full <= cfg.reg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (slots_in_use == '0)
      slots = PW'(1);
    else if (32'(slots_in_use) > 32'(DEPTH))
      slots = PW'(DEPTH);
    else
      slots = PW'(slots_in_use);
  end

  assign in_item.ready = !rst && (!out_valid || result.ready);
  assign in_accept     = in_item.valid && in_item.ready;

  trb_ctrl #(.DEPTH(DEPTH), .PW(PW), .AW(AW)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .opcode       (in_item.opcode),
    .age_position (in_item.age_position),
    .stop         (stop_when_full),
    .slots        (slots),
    .stored       (stored),
    .wp           (wp),
    .st           (st),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .read_hit     (read_hit)
  );

  trb_mem #(.DEPTH(DEPTH), .STAMP_BITS(STAMP_BITS), .AW(AW)) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_begin (in_item.begin_stamp[STAMP_BITS-1:0]),
    .wr_end   (in_item.end_stamp[STAMP_BITS-1:0]),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_begin (rd_begin),
    .rd_end   (rd_end)
  );

  // status follows the state registers, which hold the shown item's aftermath
  trb_status #(.DEPTH(DEPTH), .PW(PW)) u_status (
    .stop    (stop_when_full),
    .slots   (slots),
    .wp      (wp),
    .st      (st),
    .stored  (stored),
    .overrun (overrun),
    .lost    (lost),
    .oldest  (oldest)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      read_valid <= read_hit;
    end
  end

  assign result.valid           = out_valid;
  assign result.read_valid      = read_valid;
  assign result.read_begin      = read_valid ? trb_pkg::STAMP_W'(rd_begin) : '0;
  assign result.read_end        = read_valid ? trb_pkg::STAMP_W'(rd_end) : '0;
  assign result.overrun_seen    = overrun;
  assign result.wrap_total      = st.wrap;
  assign result.write_total     = st.wc;
  assign result.oldest_sequence = oldest;
  assign result.lost_total      = lost;
  assign result.stored_count    = trb_pkg::SLOTS_W'(stored);

  `TRB_ASSERT_NOW(a_hit_needs_records, result.valid && result.read_valid, stored != '0)
  `TRB_ASSERT_NOW(a_lost_needs_overrun, result.valid && (lost != '0), overrun)
  `TRB_ASSERT_NEXT(a_write_count_step,
    in_accept && (in_item.opcode == trb_pkg::OP_LOG) && (st.wc != '1),
    st.wc == $past(st.wc) + 32'd1)

endmodule
